### rtl/slt_pkg.sv
// Package for the sorted list table: parameter defaults, operation and
// status codes, and the command struct that drives the compare-and-shift cells.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package slt_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int KEY_WIDTH_DEF = 16;
	localparam int MODE_W        = 3;
	localparam int STATUS_W      = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT   = 3'd0,
		MODE_DELETE   = 3'd1,
		MODE_RETRIEVE = 3'd2,
		MODE_RESET_IT = 3'd3,
		MODE_GET_NEXT = 3'd4,
		MODE_CLEAR    = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK     = 2'd0,
		STATUS_ABSENT = 2'd1,
		STATUS_FULL   = 2'd2,
		STATUS_END    = 2'd3
	} status_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic shift_in;   // insert: cells at or above the insert point take from the left
		logic shift_out;  // delete: cells at or above the hit take from the right
	} cell_cmd_t;

endpackage

`default_nettype wire

### rtl/slt_if.sv
// Valid/ready channel interfaces for the sorted list table: the request
// channel (mode, key) and the response channel (status and table state).
// Depends on slt_pkg.
`default_nettype none

interface slt_req_if #(
	parameter int KEY_WIDTH = slt_pkg::KEY_WIDTH_DEF
);
	import slt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [MODE_W-1:0]    mode;
	logic [KEY_WIDTH-1:0] key;

	modport source (output valid, output mode, output key, input ready);
	modport sink   (input valid, input mode, input key, output ready);
endinterface

interface slt_rsp_if #(
	parameter int KEY_WIDTH = slt_pkg::KEY_WIDTH_DEF,
	parameter int CNT_W     = $clog2(slt_pkg::DEPTH_DEF + 1)
);
	import slt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic                 found;
	logic [KEY_WIDTH-1:0] item;
	logic [CNT_W-1:0]     count;
	logic                 at_end;
	logic                 full_res;

	modport source (output valid, output status, output found, output item, output count,
		output at_end, output full_res, input ready);
	modport sink   (input valid, input status, input found, input item, input count,
		input at_end, input full_res, output ready);
endinterface

`default_nettype wire

### rtl/slt_cell.sv
// One cell of the sorted chain: holds a single key, compares it against the
// broadcast key and shifts toward either neighbor on insert or delete.
// Depends on slt_pkg.
`default_nettype none

module slt_cell #(
	parameter int KEY_WIDTH = slt_pkg::KEY_WIDTH_DEF
) (
	input  logic                 clk,
	input  slt_pkg::cell_cmd_t   cmd,
	input  logic [KEY_WIDTH-1:0] key,
	input  logic                 occupied,
	input  logic                 left_lt,
	input  logic [KEY_WIDTH-1:0] left_data,
	input  logic [KEY_WIDTH-1:0] right_data,
	output logic [KEY_WIDTH-1:0] data,
	output logic                 lt,
	output logic                 eq
);
	import slt_pkg::*;

	logic [KEY_WIDTH-1:0] data_q;

	assign data = data_q;
	assign lt   = occupied && (data_q < key);
	assign eq   = occupied && (data_q == key);

	// Cells holding smaller keys never move. On insert, the first cell not smaller
	// gets the new key, later ones the left neighbor; on delete, all take the right.
	always_ff @(posedge clk) begin
		if (cmd.shift_in && !lt) begin
			data_q <= left_lt ? key : left_data;
		end else if (cmd.shift_out && !lt) begin
			data_q <= right_data;
		end
	end

endmodule

`default_nettype wire

### rtl/sorted_list_table_core.sv
// Sorted list table: an ascending table of up to DEPTH keys, duplicates
// allowed, held in a chain of compare-and-shift cells.
// Channels: req (mode, key) in and rsp (status, found, item, count, at_end,
// full_res) out, both valid/ready; a transaction completes when valid and
// ready are high at a rising edge of clk.
// Every request yields exactly one response. The request updates the table
// and loads its response into the output register at the edge where it is
// accepted.
// Throughput is one request per cycle while rsp.ready is high or no response
// is pending: all cells compare against the key in parallel and shift in the
// same edge, so every mode completes at the edge where it is accepted.
// The output register holds a pending response while rsp.ready is low; a
// new request is accepted in the same cycle that response is taken, and
// req.ready is low only while a response is pending and rsp.ready is low.
// arst_n clears the count, the iterator and the response valid at once; key
// storage is not cleared and is read only below the count.
// Full-table inserts, deletes of absent keys and get-next past the end
// report a status code and leave the table untouched.
// Depends on slt_pkg, slt_if and slt_cell.
`default_nettype none

module sorted_list_table_core #(
	parameter int DEPTH     = slt_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = slt_pkg::KEY_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	slt_req_if.sink    req,
	slt_rsp_if.source  rsp
);
	import slt_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] iter_q, iter_d;
	logic             rsp_valid_q;

	logic                 accept;
	logic                 full;
	logic                 hit;
	cell_cmd_t            cmd;
	logic [STATUS_W-1:0]  status_d;
	logic                 found_d;
	logic [KEY_WIDTH-1:0] item_d;

	logic [KEY_WIDTH-1:0] data_vec [DEPTH];
	logic [DEPTH-1:0]     lt_vec;
	logic [DEPTH-1:0]     eq_vec;

	logic [STATUS_W-1:0]  status_q;
	logic                 found_q;
	logic [KEY_WIDTH-1:0] item_q;
	logic [CNT_W-1:0]     count_out_q;
	logic                 at_end_q;
	logic                 full_res_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == DEPTH_C);
	assign hit       = |eq_vec;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                 left_lt;
		logic [KEY_WIDTH-1:0] left_data;
		logic [KEY_WIDTH-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_lt   = 1'b1;
			assign left_data = req.key;
		end else begin : g_inner
			assign left_lt   = lt_vec[i-1];
			assign left_data = data_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data = data_vec[i];
		end else begin : g_body
			assign right_data = data_vec[i+1];
		end

		slt_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.key       (req.key),
			.occupied  (count_q > CNT_W'(i)),
			.left_lt   (left_lt),
			.left_data (left_data),
			.right_data(right_data),
			.data      (data_vec[i]),
			.lt        (lt_vec[i]),
			.eq        (eq_vec[i])
		);
	end

	always_comb begin
		cmd      = '0;
		count_d  = count_q;
		iter_d   = iter_q;
		status_d = STATUS_OK;
		found_d  = 1'b0;
		item_d   = '0;
		case (req.mode)
			MODE_INSERT: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					cmd.shift_in = accept;
					count_d      = count_q + CNT_W'(1);
				end
			end
			MODE_DELETE: begin
				if (hit) begin
					cmd.shift_out = accept;
					count_d       = count_q - CNT_W'(1);
					if (iter_q > count_d) begin
						iter_d = count_d;
					end
				end else begin
					status_d = STATUS_ABSENT;
				end
			end
			MODE_RETRIEVE: begin
				// A hit means the stored key equals the request key.
				found_d = hit;
				item_d  = hit ? req.key : '0;
			end
			MODE_RESET_IT: begin
				iter_d = '0;
			end
			MODE_GET_NEXT: begin
				if (iter_q < count_q) begin
					item_d = data_vec[iter_q[IDX_W-1:0]];
					iter_d = iter_q + CNT_W'(1);
				end else begin
					status_d = STATUS_END;
				end
			end
			MODE_CLEAR: begin
				count_d = '0;
				iter_d  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			iter_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				iter_q      <= iter_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			found_q     <= found_d;
			item_q      <= item_d;
			count_out_q <= count_d;
			at_end_q    <= (iter_d >= count_d);
			full_res_q  <= (count_d == DEPTH_C);
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = status_q;
	assign rsp.found    = found_q;
	assign rsp.item     = item_q;
	assign rsp.count    = count_out_q;
	assign rsp.at_end   = at_end_q;
	assign rsp.full_res = full_res_q;

endmodule

`default_nettype wire

### rtl/slt_checker.sv
// Port-level checks for the sorted list table, attached to the top level
// by the bind statement at the end of this file.
// Depends on slt_pkg and sorted_list_table_core.
`default_nettype none

module slt_checker #(
	parameter int DEPTH     = slt_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = slt_pkg::KEY_WIDTH_DEF,
	parameter int CNT_W     = $clog2(DEPTH + 1)
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [slt_pkg::STATUS_W-1:0]  status,
	input logic                          found,
	input logic [KEY_WIDTH-1:0]          item,
	input logic [CNT_W-1:0]              count,
	input logic                          at_end,
	input logic                          full_res
);
	import slt_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	// Each accepted request produces a response in the following cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no response after accepted request");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (count <= DEPTH_C) && (full_res == (count == DEPTH_C)))
		else $error("count or full flag inconsistent");

	a_status_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STATUS_FULL) |-> full_res)
		else $error("full status on a table that is not full");

	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STATUS_END) |-> at_end && (item == '0) && !found)
		else $error("end status without iterator at end");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(item) && $stable(count))
		else $error("stalled response changed");

endmodule

bind sorted_list_table_core slt_checker #(
	.DEPTH    (DEPTH),
	.KEY_WIDTH(KEY_WIDTH)
) u_slt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status   (rsp.status),
	.found    (rsp.found),
	.item     (rsp.item),
	.count    (rsp.count),
	.at_end   (rsp.at_end),
	.full_res (rsp.full_res)
);

`default_nettype wire
